// ----- sv/pwo_pkg.sv -----
// shared types and constants of the polyblep wavetable oscillator
package pwo_pkg;

	// waveform selection codes
	typedef enum logic [1:0] {
		MODE_SAW      = 2'd0,
		MODE_SQUARE   = 2'd1,
		MODE_TRIANGLE = 2'd2,
		MODE_TABLE    = 2'd3
	} wave_mode_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_WAVE_MODE    = 2'd0,
		REG_PHASE_STEP   = 2'd1,
		REG_PULSE_WIDTH  = 2'd2,
		REG_TABLE_LENGTH = 2'd3
	} reg_index_t;

	// request to the polyblep residual unit
	typedef struct packed {
		logic        start;
		logic [15:0] t;
		logic [15:0] dt;
	} blep_req_t;

	// answer of the polyblep residual unit
	typedef struct packed {
		logic        done;
		logic [16:0] res;
	} blep_rsp_t;

	// residual arithmetic
	localparam logic [17:0] BLEP_FULL = 18'd32767;

	// sample arithmetic, 20 bit two's complement
	localparam logic signed [19:0] AMP     = 20'sd32767;
	localparam logic signed [19:0] TRI_OFS = 20'sd98301;
	localparam logic signed [19:0] SAT_LO  = -20'sd65536;
	localparam logic signed [19:0] SAT_HI  = 20'sd65535;

	// pulse width mapping
	localparam logic [7:0]  PW_HALF_CODE = 8'd64;
	localparam logic [17:0] PW_LOW_BASE  = 18'd16384;
	localparam logic [17:0] PW_HIGH_BASE = 18'd32768;
	localparam logic [17:0] PW_MIN       = 18'd4096;
	localparam logic [17:0] PW_MAX       = 18'd61440;

	// reset values of the configuration registers
	localparam logic [7:0]  PULSE_WIDTH_RESET  = 8'd64;
	localparam logic [11:0] TABLE_LENGTH_RESET = 12'd2;

endpackage

// ----- sv/pwo_ram.sv -----
// generic single write, single read ram with registered read data
module pwo_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/pwo_blep.sv -----
// polyblep residual unit: iterative divider, 4 quotient bits a cycle, then square and combine
module pwo_blep (
	input  logic               clk,
	input  logic               arst_n,
	input  pwo_pkg::blep_req_t req,
	output pwo_pkg::blep_rsp_t rsp
);

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_SQR,
		B_OUT
	} bstate_t;

	typedef enum logic [1:0] {
		BR_NONE,
		BR_RISE,
		BR_FALL
	} region_t;

	bstate_t     state_q;
	logic [1:0]  cnt_q;
	logic        done_q;
	logic [16:0] res_q;

	region_t     region_q;
	logic [16:0] rem_q;
	logic [15:0] numlo_q;
	logic [15:0] quo_q;
	logic [15:0] dt_q;
	logic [29:0] sq_q;

	region_t     region;
	logic [31:0] num;
	logic [16:0] u_dist;
	logic [16:0] div_rem;
	logic [15:0] div_lo;
	logic [15:0] div_quo;
	logic [17:0] two_q;
	logic [17:0] sq_sh;
	logic [17:0] res_rise;
	logic [17:0] res_fall;
	logic [16:0] res_next;

	// classify the phase and form the dividend
	always_comb begin
		u_dist = 17'h10000 - {1'b0, req.t};
		if (req.t < req.dt) begin
			region = BR_RISE;
			num    = {1'b0, req.t, 15'b0};
		end else if (({1'b0, req.t} + {1'b0, req.dt}) > 17'h10000) begin
			region = BR_FALL;
			num    = {u_dist[16:0], 15'b0} - {15'b0, u_dist};
		end else begin
			region = BR_NONE;
			num    = 32'd0;
		end
	end

	// four restoring division steps per cycle
	always_comb begin : div_step
		logic [16:0] r;
		logic [15:0] nl;
		logic [15:0] q;
		r  = rem_q;
		nl = numlo_q;
		q  = quo_q;
		for (int i = 0; i < 4; i++) begin
			r  = {r[15:0], nl[15]};
			nl = {nl[14:0], 1'b0};
			if (r >= {1'b0, dt_q}) begin
				r = r - {1'b0, dt_q};
				q = {q[14:0], 1'b1};
			end else begin
				q = {q[14:0], 1'b0};
			end
		end
		div_rem = r;
		div_lo  = nl;
		div_quo = q;
	end

	// combine quotient and its square into the residual
	always_comb begin
		two_q    = {2'b00, quo_q[14:0], 1'b0};
		sq_sh    = {3'b000, sq_q[29:15]};
		res_rise = two_q - sq_sh - pwo_pkg::BLEP_FULL;
		res_fall = sq_sh - two_q + pwo_pkg::BLEP_FULL;
		case (region_q)
			BR_RISE: res_next = res_rise[16:0];
			BR_FALL: res_next = res_fall[16:0];
			default: res_next = 17'd0;
		endcase
	end

	// sequencer with registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q   <= 2'd0;
			done_q  <= 1'b0;
			res_q   <= 17'd0;
		end else begin
			done_q <= (state_q == B_OUT);
			case (state_q)
				B_IDLE: begin
					if (req.start) begin
						cnt_q   <= 2'd0;
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= B_SQR;
					end
				end
				B_SQR: begin
					state_q <= B_OUT;
				end
				B_OUT: begin
					res_q   <= res_next;
					state_q <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && req.start) begin
			region_q <= region;
			rem_q    <= {1'b0, num[31:16]};
			numlo_q  <= num[15:0];
			quo_q    <= 16'd0;
			dt_q     <= req.dt;
		end else if (state_q == B_DIV) begin
			rem_q   <= div_rem;
			numlo_q <= div_lo;
			quo_q   <= div_quo;
		end
		if (state_q == B_SQR) begin
			sq_q <= quo_q[14:0] * quo_q[14:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

// ----- sv/polyblep_wavetable_oscillator_unit.sv -----
// Phase-accumulator oscillator giving one 17-bit sample per render item: polyblep saw,
// polyblep square, triangle or interpolated wavetable; table-write items load the wavetable.
// One item is in work at a time. A table write goes straight to the ram; a triangle sample
// goes straight to the final stage; a wavetable sample takes one multiply for the table
// position, the two neighboring entries read in consecutive cycles through the single ram
// read port, then one multiply for the interpolation; a saw and a square wait on the shared
// polyblep unit, which retires four quotient bits a cycle, then squares and combines;
// it runs once for the saw and twice for the square. A finished sample waits in its last
// stage until the output register is free and then waits in the output register while the
// next item is taken. Entries of the table must be written before a wavetable sample reads
// them.
module polyblep_wavetable_oscillator_unit #(
	parameter int unsigned TABLE_DEPTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,   // req_type
	input  logic [47:0] s_tdata,   // phase_mod[15:0], table_index[26:16], table_value[42:27]
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // sample[16:0]
);

	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int NW   = $clog2(TABLE_DEPTH + 1);
	localparam int EXTW = (AW > 11) ? AW : 11;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_B1_GO,
		ST_B1_WAIT,
		ST_B2_GO,
		ST_B2_WAIT,
		ST_TMUL,
		ST_RDA,
		ST_RDB,
		ST_RDW,
		ST_LERP,
		ST_FINAL
	} state_t;

	// control and configuration
	state_t              state_q;
	logic                m_valid_q;
	logic [16:0]         sample_q;
	logic [31:0]         acc_q;
	pwo_pkg::wave_mode_t wave_mode_q;
	logic [31:0]         phase_step_q;
	logic [7:0]          pulse_width_q;
	logic [11:0]         table_length_q;

	// payload
	logic [31:0]         ph_q;
	logic [15:0]         t_q;
	logic [16:0]         b1_q;
	logic [16:0]         b2_q;
	logic [AW-1:0]       idx_q;
	logic [15:0]         frac_q;
	logic [15:0]         a_q;
	logic [16:0]         diff_q;
	logic signed [33:0]  prod_q;

	// input fields
	logic                req_type;
	logic [15:0]         phase_mod;
	logic [10:0]         table_index;
	logic [15:0]         table_value;

	logic                in_acc;
	logic                render_acc;
	logic [31:0]         ph_next;
	logic [15:0]         dt;
	logic [17:0]         pw_raw;
	logic [15:0]         pw;
	logic [15:0]         t2;
	logic [NW-1:0]       n_len;
	logic [31+NW:0]      pos;
	logic [NW-1:0]       idx_inc;
	logic [AW-1:0]       nxt;
	logic [EXTW-1:0]     widx_ext;
	logic                wr_en;
	logic [AW-1:0]       raddr;
	logic [15:0]         rdata;
	logic                out_free;

	logic signed [19:0]  b1_ext;
	logic signed [19:0]  b2_ext;
	logic signed [19:0]  tri_lin;
	logic signed [19:0]  s_raw;
	logic [16:0]         s_sat;

	pwo_pkg::blep_req_t  blep_req;
	pwo_pkg::blep_rsp_t  blep_rsp;

	// field unpacking
	assign req_type    = s_tuser;
	assign phase_mod   = s_tdata[15:0];
	assign table_index = s_tdata[26:16];
	assign table_value = s_tdata[42:27];

	assign s_tready   = (state_q == ST_IDLE);
	assign in_acc     = s_tvalid & s_tready;
	assign render_acc = in_acc & ~req_type;
	assign out_free   = ~m_valid_q | m_tready;

	// read phase and step in 16-bit phase units
	assign ph_next = acc_q + {phase_mod, 16'b0};
	assign dt      = (phase_step_q[31:16] == 16'd0) ? 16'd1 : phase_step_q[31:16];

	// pulse width from its code, clamped
	always_comb begin
		if (pulse_width_q < pwo_pkg::PW_HALF_CODE) begin
			pw_raw = pwo_pkg::PW_LOW_BASE + {2'b00, pulse_width_q, 8'b0};
		end else begin
			pw_raw = pwo_pkg::PW_HIGH_BASE
				+ {2'b00, pulse_width_q - pwo_pkg::PW_HALF_CODE, 8'b0};
		end
		if (pw_raw < pwo_pkg::PW_MIN) begin
			pw = pwo_pkg::PW_MIN[15:0];
		end else if (pw_raw > pwo_pkg::PW_MAX) begin
			pw = pwo_pkg::PW_MAX[15:0];
		end else begin
			pw = pw_raw[15:0];
		end
	end

	// phase of the falling edge
	assign t2 = t_q - pw;

	// residual unit requests
	assign blep_req.start = (state_q == ST_B1_GO) || (state_q == ST_B2_GO);
	assign blep_req.t     = (state_q == ST_B2_GO) ? t2 : t_q;
	assign blep_req.dt    = dt;

	pwo_blep u_blep (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (blep_req),
		.rsp    (blep_rsp)
	);

	// table length in use
	always_comb begin
		if (32'(table_length_q) < 32'd2) begin
			n_len = NW'(2);
		end else if (32'(table_length_q) > TABLE_DEPTH) begin
			n_len = NW'(TABLE_DEPTH);
		end else begin
			n_len = NW'(table_length_q);
		end
	end

	// table position and neighbor index
	assign pos     = ph_q * n_len;
	assign idx_inc = NW'(idx_q) + NW'(1);
	assign nxt     = (idx_inc >= n_len) ? '0 : idx_inc[AW-1:0];

	// table writes go straight to the ram
	assign widx_ext = EXTW'(table_index);
	assign wr_en    = in_acc & req_type & (32'(table_index) < TABLE_DEPTH);
	assign raddr    = (state_q == ST_RDB) ? nxt : idx_q;

	pwo_ram #(
		.WIDTH (16),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (widx_ext[AW-1:0]),
		.wdata (table_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	// sample of the selected waveform, saturated
	always_comb begin
		b1_ext  = {{3{b1_q[16]}}, b1_q};
		b2_ext  = {{3{b2_q[16]}}, b2_q};
		tri_lin = $signed({3'b000, t_q, 1'b0});
		case (wave_mode_q)
			pwo_pkg::MODE_SQUARE: begin
				s_raw = ((t_q < pw) ? pwo_pkg::AMP : -pwo_pkg::AMP) + b1_ext - b2_ext;
			end
			pwo_pkg::MODE_TRIANGLE: begin
				s_raw = t_q[15] ? (pwo_pkg::TRI_OFS - tri_lin) : (tri_lin - pwo_pkg::AMP);
			end
			pwo_pkg::MODE_TABLE: begin
				s_raw = $signed({{4{a_q[15]}}, a_q})
					+ $signed({{2{prod_q[33]}}, prod_q[33:16]});
			end
			default: begin
				s_raw = $signed({4'b0000, t_q}) - pwo_pkg::AMP - b1_ext;
			end
		endcase
		if (s_raw < pwo_pkg::SAT_LO) begin
			s_sat = pwo_pkg::SAT_LO[16:0];
		end else if (s_raw > pwo_pkg::SAT_HI) begin
			s_sat = pwo_pkg::SAT_HI[16:0];
		end else begin
			s_sat = s_raw[16:0];
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			sample_q  <= 17'd0;
		end else begin
			// load a finished sample, clear once it is taken
			if (state_q == ST_FINAL && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (render_acc) begin
						case (wave_mode_q)
							pwo_pkg::MODE_TRIANGLE: state_q <= ST_FINAL;
							pwo_pkg::MODE_TABLE:    state_q <= ST_TMUL;
							default:                state_q <= ST_B1_GO;
						endcase
					end
				end
				ST_B1_GO:   state_q <= ST_B1_WAIT;
				ST_B1_WAIT: begin
					if (blep_rsp.done) begin
						state_q <= (wave_mode_q == pwo_pkg::MODE_SQUARE) ? ST_B2_GO : ST_FINAL;
					end
				end
				ST_B2_GO:   state_q <= ST_B2_WAIT;
				ST_B2_WAIT: begin
					if (blep_rsp.done) begin
						state_q <= ST_FINAL;
					end
				end
				ST_TMUL:    state_q <= ST_RDA;
				ST_RDA:     state_q <= ST_RDB;
				ST_RDB:     state_q <= ST_RDW;
				ST_RDW:     state_q <= ST_LERP;
				ST_LERP:    state_q <= ST_FINAL;
				ST_FINAL: begin
					if (out_free) begin
						sample_q <= s_sat;
						state_q  <= ST_IDLE;
					end
				end
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

	// phase accumulator and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q          <= 32'd0;
			wave_mode_q    <= pwo_pkg::MODE_SAW;
			phase_step_q   <= 32'd0;
			pulse_width_q  <= pwo_pkg::PULSE_WIDTH_RESET;
			table_length_q <= pwo_pkg::TABLE_LENGTH_RESET;
		end else begin
			if (render_acc) begin
				acc_q <= acc_q + phase_step_q;
			end
			if (cfg_we) begin
				case (cfg_index)
					pwo_pkg::REG_WAVE_MODE:    wave_mode_q    <= pwo_pkg::wave_mode_t'(cfg_data[1:0]);
					pwo_pkg::REG_PHASE_STEP:   phase_step_q   <= cfg_data;
					pwo_pkg::REG_PULSE_WIDTH:  pulse_width_q  <= cfg_data[7:0];
					pwo_pkg::REG_TABLE_LENGTH: table_length_q <= cfg_data[11:0];
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (render_acc) begin
			ph_q <= ph_next;
			t_q  <= ph_next[31:16];
		end
		if (state_q == ST_B1_WAIT && blep_rsp.done) begin
			b1_q <= blep_rsp.res;
		end
		if (state_q == ST_B2_WAIT && blep_rsp.done) begin
			b2_q <= blep_rsp.res;
		end
		if (state_q == ST_TMUL) begin
			idx_q  <= pos[32 +: AW];
			frac_q <= pos[31:16];
		end
		if (state_q == ST_RDB) begin
			a_q <= rdata;
		end
		if (state_q == ST_RDW) begin
			diff_q <= {rdata[15], rdata} - {a_q[15], a_q};
		end
		if (state_q == ST_LERP) begin
			prod_q <= $signed(diff_q) * $signed({1'b0, frac_q});
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'b0, sample_q};

endmodule

// ----- sv/pwo_check.sv -----
// port-level checks of the oscillator, bound to the top level
module pwo_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic [47:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a table write gives no result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser && !m_tvalid |=> !m_tvalid)
		else $error("table write produced a result");

	// a render item blocks the input while it is in work
	a_render_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser |=> !s_tready)
		else $error("input taken during a render");

	// padding above the sample stays zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:17] == 7'd0)
		else $error("nonzero padding on result");

endmodule

bind polyblep_wavetable_oscillator_unit pwo_check u_pwo_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- dv/polyblep_wavetable_oscillator_unit_tb.sv -----
// self-checking testbench of the polyblep wavetable oscillator unit
`timescale 1ns / 1ps

module polyblep_wavetable_oscillator_unit_tb;
	import pwo_pkg::*;

	localparam int unsigned DEPTH        = 2048;
	localparam int unsigned RANDOM_ITEMS = 1760;
	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned SETTLE       = 24;
	localparam int unsigned WINDOW       = 64;

	// predicts oscillator samples and checks the result stream in order
	class osc_scoreboard;
		logic [31:0]        phase_acc;
		logic [1:0]         mode;
		logic [31:0]        step;
		logic [7:0]         pw_code;
		logic [11:0]        tlen;
		logic signed [15:0] wtab [DEPTH];
		logic [16:0]        expected_samples [$];
		int unsigned        failures;

		function new();
			phase_acc = '0;
			mode      = MODE_SAW;
			step      = '0;
			pw_code   = PULSE_WIDTH_RESET;
			tlen      = TABLE_LENGTH_RESET;
			failures  = 0;
			foreach (wtab[i]) wtab[i] = '0;
		endfunction

		function void set_reg(reg_index_t idx, logic [31:0] v);
			case (idx)
				REG_WAVE_MODE:    mode = v[1:0];
				REG_PHASE_STEP:   step = v;
				REG_PULSE_WIDTH:  pw_code = v[7:0];
				REG_TABLE_LENGTH: tlen = v[11:0];
				default: ;
			endcase
		endfunction

		// polyblep residual on 16-bit phase fractions
		function int blep_residual(int unsigned t, int unsigned dt);
			int          x;
			int unsigned m;
			if (dt == 0) return 0;
			if (t < dt) begin
				x = int'((t << 15) / dt);
				return x + x - ((x * x) >>> 15) - 32767;
			end
			if (t + dt > 32'd65536) begin
				m = ((32'd65536 - t) * 32'd32767) / dt;
				x = -int'(m);
				return x + x + int'((m * m) >> 15) + 32767;
			end
			return 0;
		endfunction

		// linear interpolation between two neighboring table frames
		function int table_interp(logic [31:0] ph);
			longint unsigned n;
			longint unsigned pos;
			int unsigned     idx;
			int unsigned     nxt;
			int unsigned     frac;
			int              a;
			int              b;
			longint          d;
			n = tlen;
			if (n < 2) n = 2;
			if (n > DEPTH) n = DEPTH;
			pos = {32'd0, ph} * n;
			idx = int'(pos >> 32);
			if (idx >= n) idx = int'(n) - 1;
			frac = int'((pos >> 16) & 64'hFFFF);
			nxt = (idx + 1 >= n) ? 0 : idx + 1;
			a = wtab[idx];
			b = wtab[nxt];
			d = longint'(b - a) * longint'({32'd0, frac});
			if (d < 0) return a - int'((-d + 65535) >>> 16);
			return a + int'(d >>> 16);
		endfunction

		// one accepted input item: table write or sample render
		function void note_item(bit req, logic [15:0] pm, logic [10:0] ti, logic [15:0] tv);
			logic [31:0] ph;
			int unsigned t;
			int unsigned dt;
			int unsigned pw;
			int unsigned code;
			int          s;
			if (req) begin
				wtab[ti] = tv;
				return;
			end
			ph = phase_acc + {pm, 16'h0000};
			t = ph[31:16];
			dt = step[31:16];
			if (dt < 1) dt = 1;
			case (wave_mode_t'(mode))
				MODE_SQUARE: begin
					code = pw_code;
					if (code < 64) pw = 16384 + code * 256;
					else pw = 32768 + (code - 64) * 256;
					if (pw < 4096) pw = 4096;
					if (pw > 61440) pw = 61440;
					s = (t < pw) ? 32767 : -32767;
					s += blep_residual(t, dt);
					s -= blep_residual((t + (32'd65536 - pw)) & 32'hFFFF, dt);
				end
				MODE_TRIANGLE: begin
					if (t < 32768) s = int'(t) * 2 - 32767;
					else s = 98301 - int'(t) * 2;
				end
				MODE_TABLE: s = table_interp(ph);
				default: s = int'(t) - 32767 - blep_residual(t, dt);
			endcase
			if (s < -65536) s = -65536;
			if (s > 65535) s = 65535;
			phase_acc = phase_acc + step;
			expected_samples.push_back(s[16:0]);
		endfunction

		// one accepted result item against the oldest prediction
		function void check_sample(logic [16:0] got);
			logic [16:0] want;
			if (expected_samples.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected sample %0d with no prediction pending", $signed(got));
				return;
			end
			want = expected_samples.pop_front();
			if (got !== want) begin
				failures++;
				if (failures <= 10)
					$display("sample mismatch: expected %0d, got %0d", $signed(want),
						$signed(got));
			end
		endfunction

		function int unsigned outstanding();
			return expected_samples.size();
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = REG_WAVE_MODE;
	logic [31:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic        s_tuser   = 1'b0;
	logic [47:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;

	osc_scoreboard sb = new();
	bit            filled [DEPTH];
	bit            calm        = 1'b0;
	int unsigned   tx_idle_pct = 20;
	int unsigned   rx_idle_pct = 20;
	int unsigned   cycles      = 0;

	polyblep_wavetable_oscillator_unit #(
		.TABLE_DEPTH(DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// cycle count and watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("[polyblep_wavetable_oscillator_unit] ERROR");
		$finish;
	end

	// result side: random stall bursts
	initial begin
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 99) < rx_idle_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_sample(m_tdata[16:0]);
	end

	// present one item, return at the edge that accepts it
	task automatic send_item(bit req, logic [15:0] pm, logic [10:0] ti, logic [15:0] tv);
		if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {5'd0, tv, ti, pm};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_item(req, pm, ti, tv);
	endtask

	task automatic render(logic [15:0] pm);
		send_item(1'b0, pm, 11'($urandom), 16'($urandom));
	endtask

	task automatic write_entry(int unsigned idx, logic [15:0] val);
		send_item(1'b1, 16'($urandom), idx[10:0], val);
		filled[idx] = 1'b1;
	endtask

	// hold off until every predicted sample has come out, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	// rewrite every register once the block is idle
	task automatic set_regs(wave_mode_t mode, logic [31:0] step, logic [7:0] pw,
		logic [11:0] tlen);
		drain();
		write_reg(REG_WAVE_MODE, 32'(mode));
		write_reg(REG_PHASE_STEP, step);
		write_reg(REG_PULSE_WIDTH, 32'(pw));
		write_reg(REG_TABLE_LENGTH, 32'(tlen));
		cfg_we <= 1'b0;
	endtask

	// frames a wavetable sample may read under a table length setting
	function automatic int unsigned frames_in_use(logic [11:0] tlen);
		if (tlen < 2) return 2;
		if (tlen > DEPTH) return DEPTH;
		return tlen;
	endfunction

	// modulation that steers a long-table read into the first frames or the last one
	function automatic logic [15:0] aimed_mod(int unsigned n);
		int unsigned lo_max;
		int unsigned hi_min;
		int unsigned target;
		lo_max = (WINDOW - 1) * 65536 / n - 1;
		hi_min = ((n - 1) * 65536 + n - 1) / n;
		if ($urandom_range(0, 3) == 0) target = $urandom_range(hi_min, 65535);
		else target = $urandom_range(0, lo_max);
		return 16'(target) - sb.phase_acc[31:16];
	endfunction

	// stimulus
	initial begin
		wave_mode_t    mode;
		logic [31:0]   step;
		logic [7:0]    pw;
		logic [11:0]   tlen;
		int unsigned   n_eff;
		int unsigned   len;
		int unsigned   idx;
		int unsigned   done_items;
		int unsigned   phase_no;
		int unsigned   pick;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: saw at zero step, modulation extremes
		render(16'h0000);
		render(16'h7FFF);
		render(16'h8000);
		render(16'hFFFF);

		// square at full step, narrowest code
		set_regs(MODE_SQUARE, 32'hFFFF_FFFF, 8'd0, 12'd2);
		render(16'h4000);
		render(16'hC000);
		render(16'h3FFF);

		// square with widest code, clamped
		set_regs(MODE_SQUARE, 32'h0800_0000, 8'd255, 12'd2);
		render(16'h0000);
		render(16'h7FFF);
		render(16'hF000);

		// triangle around its peak
		set_regs(MODE_TRIANGLE, 32'h4000_0000, 8'd64, 12'd2);
		render(16'h0000);
		render(16'h0000);
		render(16'h7FFF);
		render(16'h8000);

		// table value extremes, lengths below the minimum
		write_entry(0, 16'h7FFF);
		write_entry(1, 16'h8000);
		write_entry(DEPTH - 1, 16'hFFFF);
		set_regs(MODE_TABLE, 32'h1234_5678, 8'd64, 12'd0);
		render(16'h0000);
		render(16'h8000);
		render(16'($urandom));
		set_regs(MODE_TABLE, 32'hFFFF_FFFF, 8'd255, 12'd1);
		render(16'h7FFF);
		render(16'($urandom));

		// random phases of random settings
		done_items = 0;
		phase_no = 0;
		while (done_items < RANDOM_ITEMS) begin
			calm = (done_items >= RANDOM_ITEMS * 4 / 5);
			tx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
			rx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);

			mode = wave_mode_t'($urandom_range(0, 3));
			pick = $urandom_range(0, 9);
			case (pick)
				0: step = 32'h0000_0000;
				1: step = 32'hFFFF_FFFF;
				2: step = $urandom_range(0, 32'h0002_0000);
				3: step = 32'h8000_0000 + $urandom_range(0, 32'h0FFF_FFFF);
				default: step = $urandom;
			endcase
			pick = $urandom_range(0, 5);
			case (pick)
				0: pw = 8'd0;
				1: pw = 8'd255;
				2: pw = 8'd64;
				default: pw = 8'($urandom);
			endcase
			pick = $urandom_range(0, 9);
			case (pick)
				0: tlen = 12'($urandom_range(0, 1));
				1: tlen = ($urandom_range(0, 1) == 0) ? 12'd2048 : 12'd4095;
				default: tlen = 12'($urandom_range(2, 64));
			endcase
			// one phase at full table length, one beyond it
			if (phase_no == 1) begin
				mode = MODE_TABLE;
				tlen = 12'd2048;
			end
			if (phase_no == 6) begin
				mode = MODE_TABLE;
				tlen = 12'd4095;
			end
			set_regs(mode, step, pw, tlen);

			// every frame a sample can read gets written first; a long table is
			// read only in its first frames and its last one
			n_eff = frames_in_use(tlen);
			if (mode == MODE_TABLE) begin
				for (int i = 0; i < n_eff; i++) begin
					if ((i < WINDOW || i == n_eff - 1) && !filled[i])
						write_entry(i, 16'($urandom));
				end
			end

			len = $urandom_range(20, 120);
			for (int k = 0; k < len; k++) begin
				if (phase_no == 3 && k == len / 2) drain();
				if ($urandom_range(0, 4) == 0) begin
					if (mode == MODE_TABLE && $urandom_range(0, 1) == 0)
						idx = $urandom_range(0, n_eff - 1);
					else
						idx = $urandom_range(0, DEPTH - 1);
					write_entry(idx, 16'($urandom));
				end else if (mode == MODE_TABLE && n_eff > WINDOW) begin
					render(aimed_mod(n_eff));
				end else begin
					render(($urandom_range(0, 5) == 0) ? 16'h0000 : 16'($urandom));
				end
				done_items++;
			end
			phase_no++;
		end

		drain();
		if (sb.outstanding() != 0) sb.failures++;
		if (sb.failures == 0) begin
			$display("[polyblep_wavetable_oscillator_unit] OK");
		end else begin
			$display("[polyblep_wavetable_oscillator_unit] ERROR");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/pwo_pkg.sv
sv/pwo_ram.sv
sv/pwo_blep.sv
sv/polyblep_wavetable_oscillator_unit.sv
sv/pwo_check.sv
dv/polyblep_wavetable_oscillator_unit_tb.sv
